// ===== sv/fat12_cluster_chain_sector_walker_defines.svh =====
// Assertion macros shared by the sector walker RTL.
// Each macro samples on the rising clock and is disabled while reset is high.
`ifndef FAT12_CLUSTER_CHAIN_SECTOR_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_SECTOR_WALKER_DEFINES_SVH

// Same-cycle implication between two conditions.
`define FCCW_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Implication that must hold in the cycle after the condition.
`define FCCW_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== sv/fccw_pkg.sv =====
// Package for the FAT12 cluster chain sector walker.
// Holds the action codes, controller states and control/status structs.
`default_nettype none

package fccw_pkg;

   // Item actions.
   typedef enum logic [1:0] {
      ACT_LOAD        = 2'd0,
      ACT_OPEN_CHAIN  = 2'd1,
      ACT_OPEN_LINEAR = 2'd2,
      ACT_ADVANCE     = 2'd3
   } action_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_HI,
      ST_FETCH_DONE,
      ST_CALC,
      ST_OUT
   } state_type;

   // Configuration register indexes.
   localparam logic CSR_DATA_LBA = 1'b0;
   localparam logic CSR_SPC      = 1'b1;

   // Cluster values at or above this mark end a chain.
   localparam logic [11:0] CLUSTER_END   = 12'hFF8;
   // First cluster number of the data area.
   localparam logic [31:0] FIRST_CLUSTER = 32'd2;
   // Reset value of the cluster size register.
   localparam logic [7:0]  SPC_RESET     = 8'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mem_write;   // write one table byte
      logic item_apply;  // apply an open or advance item to the walk state
      logic rd_hi;       // read the high byte of the table entry
      logic fetch_lo;    // capture the low byte of the entry
      logic fetch_hi;    // build the next cluster from both bytes
      logic mul_load;    // register the cluster offset product
      logic out_load;    // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;       // action of the item on the input channel
      logic       wrap_needed;  // advance item leaves the current cluster
      logic       out_free;     // result register can take a new item
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/fccw_ifs.sv =====
// Valid/ready channel interfaces of the sector walker: request, result, config.
// No dependencies.
`default_nettype none

interface fccw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [12:0] table_index;
   logic [7:0]  table_byte;
   logic [11:0] start_cluster;
   logic [31:0] start_lba;

   modport source (output valid, action, table_index, table_byte, start_cluster,
                   start_lba, input ready);
   modport sink (input valid, action, table_index, table_byte, start_cluster,
                 start_lba, output ready);
endinterface

interface fccw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sector_lba;
   logic        end_of_chain;
   logic [11:0] cluster_now;

   modport source (output valid, sector_lba, end_of_chain, cluster_now, input ready);
   modport sink (input valid, sector_lba, end_of_chain, cluster_now, output ready);
endinterface

interface fccw_csr_if;
   logic        valid;
   logic        ready;
   logic        reg_index;
   logic [31:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/fccw_ctrl.sv =====
// Controller state machine of the sector walker.
// Depends on fccw_pkg and the assertion macro header.
`default_nettype none
`include "fat12_cluster_chain_sector_walker_defines.svh"

module fccw_ctrl
   import fccw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.action != ACT_LOAD) begin
               state_in = stat.wrap_needed ? ST_FETCH_HI : ST_CALC;
            end
         end
         ST_FETCH_HI:   state_in = ST_FETCH_DONE;
         ST_FETCH_DONE: state_in = ST_CALC;
         ST_CALC:       state_in = ST_OUT;
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd            = '0;
      cmd.mem_write  = accept && stat.action == ACT_LOAD;
      cmd.item_apply = accept && stat.action != ACT_LOAD;
      case (state_ff)
         ST_FETCH_HI: begin
            cmd.rd_hi    = 1'b1;
            cmd.fetch_lo = 1'b1;
         end
         ST_FETCH_DONE: cmd.fetch_hi = 1'b1;
         ST_CALC:       cmd.mul_load = 1'b1;
         ST_OUT:        cmd.out_load = stat.out_free;
         default:       cmd.rd_hi    = 1'b0;
      endcase
   end

   // A cluster change always runs through both table byte fetches.
   `FCCW_ASSERT_NEXT(a_fetch_seq, state_ff == ST_FETCH_HI, state_ff == ST_FETCH_DONE, "fetch order broken")
   // An advance that leaves its cluster must go fetch the table entry.
   `FCCW_ASSERT_NEXT(a_wrap_fetch, cmd.item_apply && stat.wrap_needed, state_ff == ST_FETCH_HI, "wrap without fetch")
   // A result never overwrites one that is still waiting.
   `FCCW_ASSERT_NOW(a_out_free, cmd.out_load, stat.out_free, "result register overrun")

endmodule

`default_nettype wire

// ===== sv/fccw_datapath.sv =====
// Datapath of the sector walker: table store, walk state, address math, result.
// Depends on fccw_pkg.
`default_nettype none

module fccw_datapath
   import fccw_pkg::*;
#(
   parameter int TABLE_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [1:0]  req_action,
   input  wire logic [12:0] req_table_index,
   input  wire logic [7:0]  req_table_byte,
   input  wire logic [11:0] req_start_cluster,
   input  wire logic [31:0] req_start_lba,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_sector_lba,
   output logic             rsp_end_of_chain,
   output logic [11:0]      rsp_cluster_now
);

   localparam int ADDR_W = $clog2(TABLE_BYTES);

   // Table store.
   logic [7:0]        table_mem [TABLE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       load_off;
   logic [12:0]       entry_off;

   // Configuration.
   logic [31:0] data_lba_ff;
   logic [7:0]  spc_ff;

   // Walk state.
   logic [11:0] cluster_ff, cluster_in;
   logic [6:0]  sector_ff, sector_in;
   logic [31:0] lin_addr_ff, lin_addr_in;
   logic        lin_mode_ff, lin_mode_in;
   logic        ended_ff, ended_in;

   // Entry bytes, product and result.
   logic [7:0]  lo_byte_ff;
   logic [15:0] entry_word;
   logic [11:0] next_cluster;
   logic [31:0] product_ff;
   logic [31:0] cluster_base;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] lba_ff, lba_in;
   logic        eoc_ff, eoc_in;
   logic [11:0] cl_out_ff, cl_out_in;

   logic [7:0]  sector_next;
   action_type  action;

   assign action      = action_type'(req_action);
   assign sector_next = {1'b0, sector_ff} + 8'd1;

   // Status to the controller.
   always_comb begin
      stat.action      = action;
      stat.wrap_needed = action == ACT_ADVANCE && !lin_mode_ff && !ended_ff &&
                         (sector_next >= spc_ff || sector_next[7]);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Table addresses: the load offset wraps at the store size, entry offset is 3n/2.
   always_comb begin
      load_off = 32'(req_table_index);
      if (load_off >= 32'(TABLE_BYTES)) begin
         load_off = load_off - 32'(TABLE_BYTES);
      end
      wr_addr   = load_off[ADDR_W-1:0];
      entry_off = 13'(cluster_ff) + 13'(cluster_ff[11:1]);
      rd_addr   = cmd.rd_hi ? ADDR_W'(entry_off + 13'd1) : ADDR_W'(entry_off);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         table_mem[wr_addr] <= req_table_byte;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_lba_ff <= '0;
         spc_ff      <= SPC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_LBA: data_lba_ff <= csr_wdata;
            CSR_SPC:      spc_ff      <= csr_wdata[7:0];
            default:      spc_ff      <= spc_ff;
         endcase
      end
   end

   // Next cluster from the packed 12-bit little-endian entry.
   assign entry_word   = {rd_data_ff, lo_byte_ff};
   assign next_cluster = cluster_ff[0] ? entry_word[15:4] : entry_word[11:0];

   // Walk state update.
   always_comb begin
      cluster_in  = cluster_ff;
      sector_in   = sector_ff;
      lin_addr_in = lin_addr_ff;
      lin_mode_in = lin_mode_ff;
      ended_in    = ended_ff;
      if (cmd.item_apply) begin
         case (action)
            ACT_OPEN_CHAIN: begin
               cluster_in  = req_start_cluster;
               sector_in   = '0;
               lin_mode_in = 1'b0;
               ended_in    = req_start_cluster >= CLUSTER_END;
            end
            ACT_OPEN_LINEAR: begin
               lin_addr_in = req_start_lba;
               lin_mode_in = 1'b1;
               ended_in    = 1'b0;
               sector_in   = '0;
               cluster_in  = '0;
            end
            ACT_ADVANCE: begin
               if (lin_mode_ff) begin
                  lin_addr_in = lin_addr_ff + 32'd1;
               end else if (!ended_ff) begin
                  sector_in = stat.wrap_needed ? 7'd0 : sector_next[6:0];
               end
            end
            default: cluster_in = cluster_ff;
         endcase
      end else if (cmd.fetch_hi) begin
         cluster_in = next_cluster;
         ended_in   = next_cluster >= CLUSTER_END;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff  <= '0;
         sector_ff   <= '0;
         lin_addr_ff <= '0;
         lin_mode_ff <= 1'b0;
         ended_ff    <= 1'b0;
      end else begin
         cluster_ff  <= cluster_in;
         sector_ff   <= sector_in;
         lin_addr_ff <= lin_addr_in;
         lin_mode_ff <= lin_mode_in;
         ended_ff    <= ended_in;
      end
   end

   // Low entry byte and cluster offset product.
   assign cluster_base = 32'(cluster_ff) - FIRST_CLUSTER;

   always_ff @(posedge clock) begin
      if (cmd.fetch_lo) begin
         lo_byte_ff <= rd_data_ff;
      end
      if (cmd.mul_load) begin
         product_ff <= cluster_base * 32'(spc_ff);
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lba_in       = lba_ff;
      eoc_in       = eoc_ff;
      cl_out_in    = cl_out_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (lin_mode_ff) begin
            lba_in    = lin_addr_ff;
            eoc_in    = 1'b0;
            cl_out_in = '0;
         end else if (ended_ff) begin
            lba_in    = '0;
            eoc_in    = 1'b1;
            cl_out_in = cluster_ff;
         end else begin
            lba_in    = data_lba_ff + product_ff + 32'(sector_ff);
            eoc_in    = 1'b0;
            cl_out_in = cluster_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      lba_ff    <= lba_in;
      eoc_ff    <= eoc_in;
      cl_out_ff <= cl_out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sector_lba   = lba_ff;
   assign rsp_end_of_chain = eoc_ff;
   assign rsp_cluster_now  = cl_out_ff;

endmodule

`default_nettype wire

// ===== sv/fat12_cluster_chain_sector_walker.sv =====
// FAT12 cluster chain sector walker, top level.
// An open or an advance within a cluster goes from acceptance through the calc and
// output states; an advance that follows the table to the next cluster first passes
// the fetch states, set by the two reads of the single table read port. A load gives
// no result. One item is in work at a time; loads are taken while a result waits.
// Synchronous reset clears the walk state and config; the table store is not cleared.
`default_nettype none

module fat12_cluster_chain_sector_walker
   import fccw_pkg::*;
#(
   parameter int TABLE_BYTES = 8192
) (
   input  wire logic   clock,
   input  wire logic   reset,
   fccw_req_if.sink    req_chan,
   fccw_rsp_if.source  rsp_chan,
   fccw_csr_if.sink    csr_chan
);

   cmd_type  cmd;
   stat_type stat;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;

   fccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fccw_datapath #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_chan.action),
      .req_table_index   (req_chan.table_index),
      .req_table_byte    (req_chan.table_byte),
      .req_start_cluster (req_chan.start_cluster),
      .req_start_lba     (req_chan.start_lba),
      .csr_we            (csr_chan.valid),
      .csr_index         (csr_chan.reg_index),
      .csr_wdata         (csr_chan.wdata),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_sector_lba    (rsp_chan.sector_lba),
      .rsp_end_of_chain  (rsp_chan.end_of_chain),
      .rsp_cluster_now   (rsp_chan.cluster_now)
   );

endmodule

`default_nettype wire
